[sv/gravity_force_direct_sum_macros.svh]
// Assertion macros used by gravity_force_direct_sum.sv.
`ifndef GRAVITY_FORCE_DIRECT_SUM_MACROS_SVH
`define GRAVITY_FORCE_DIRECT_SUM_MACROS_SVH
`ifndef SYNTHESIS
`define GFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gfd assertion failed");
`define GFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gfd assertion failed");
`else
`define GFD_ASSERT_SAME(label, ante, cons)
`define GFD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[sv/gfd_pkg.sv]
package gfd_pkg;

    localparam int MAX_BODIES_DEF = 64;
    localparam int EW = 128;
    localparam logic [6:0] DIV_STEPS = 7'd96;
    localparam logic [EW-1:0] SQRT_BIT0 = {{(EW-65){1'b0}}, 1'b1, 64'd0};

    localparam logic [1:0] CFG_BODY_COUNT = 2'd0;
    localparam logic [1:0] CFG_GRAV_CONST = 2'd1;
    localparam logic [1:0] CFG_MIN_DIST = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [6:0] BODY_COUNT_RST = 7'd0;
    localparam logic [31:0] GRAV_CONST_RST = 32'd65536;
    localparam logic [15:0] MIN_DIST_RST = 16'd7;

    typedef struct packed {
        logic               cmd;
        logic [5:0]         body_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        mass;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
    } out_item_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] mass;
    } body_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_SQRT,
        OP_DIV
    } gfd_op_e;

    typedef struct packed {
        logic          start;
        gfd_op_e       op;
        logic [EW-1:0] a;
        logic [EW-1:0] b;
    } eng_req_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_DIFF,
        S_SQX,
        S_SQY,
        S_SQZ,
        S_SQRT,
        S_R2,
        S_R3,
        S_DIV,
        S_CX,
        S_CY,
        S_CZ,
        S_FX,
        S_FY,
        S_FZ,
        S_OUT
    } state_t;

endpackage

[sv/gravity_force_direct_sum.sv]
// Channel | Direction | Handshake          | Beat
// in      | input     | in_valid/in_stall   | in_item_t: load a body or query a point
// out     | output    | out_valid/out_stall | out_item_t: field at the queried point
// cfg     | input     | cfg_we              | cfg_index, cfg_data
// A query runs all its steps on the one shared shift-add/subtract engine:
// per body the squares, the square root, the cube, the division and the
// scaling, where a body at zero distance or nearer than the minimum distance
// is dropped after the square root; then the sums are scaled.
// Reset clears control and configuration; the body table is not cleared.
// A finished result waits in the output register while loads go on.
module gravity_force_direct_sum #(
    parameter int MAX_BODIES = gfd_pkg::MAX_BODIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  gfd_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output gfd_pkg::out_item_t out_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import gfd_pkg::*;
    `include "gravity_force_direct_sum_macros.svh"

    localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int CW = $clog2(MAX_BODIES + 1);

    state_t state_reg, state_next;

    logic [6:0]  body_count_reg;
    logic [31:0] grav_reg;
    logic [15:0] min_dist_reg;

    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [CW-1:0] n_reg, i_reg;
    logic [32:0]   mx_reg, my_reg, mz_reg;
    logic          sx_reg, sy_reg, sz_reg;
    logic [31:0]   mass_reg;
    logic [65:0]   s_reg;
    logic [34:0]   r_reg;
    logic [63:0]   k_reg;
    logic signed [63:0] ax_reg, ay_reg, az_reg;
    logic [31:0]   fx_reg, fy_reg, fz_reg;
    logic          out_valid_reg;
    out_item_t     out_reg;

    eng_req_t      eng_req;
    logic          eng_busy, eng_done;
    logic [EW-1:0] eng_res;

    logic          in_acc, mem_we;
    logic [12:0]   idx_wide, cnt_wide;
    body_t         wbody, rbody;
    logic [AW-1:0] raddr;
    logic [32:0]   dx, dy, dz, amx, amy, amz;
    logic [65:0]   s_sum;
    logic [34:0]   r_res;
    logic          skip;
    logic [63:0]   k_sat;
    logic          last;
    logic          out_free;
    logic [63:0]   magx, magy, magz;

    function automatic logic signed [63:0] acc_add(input logic signed [63:0] acc,
                                                   input logic neg,
                                                   input logic [EW-1:0] p);
        logic [63:0] c;
        logic [63:0] sc;
        logic [64:0] sum;
        c = (p[EW-1:95] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : {1'b0, p[94:32]};
        sc = neg ? (64'd0 - c) : c;
        sum = {acc[63], acc} + {sc[63], sc};
        if (sum[64] != sum[63])
        begin
            return sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        return sum[63:0];
    endfunction

    function automatic logic [31:0] fin32(input logic neg, input logic [EW-1:0] p);
        logic [EW-17:0] v;
        logic [31:0] lo;
        v = p[EW-1:16];
        lo = v[31:0];
        if (!neg)
        begin
            return (v > {{(EW-48){1'b0}}, 32'h7FFF_FFFF}) ? 32'h7FFF_FFFF : lo;
        end
        return (v > {{(EW-48){1'b0}}, 32'h8000_0000}) ? 32'h8000_0000 : (32'd0 - lo);
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    assign in_acc = in_valid && !in_stall;
    assign idx_wide = 13'(in_data.body_index);
    assign mem_we = in_acc && (in_data.cmd == CMD_LOAD) && (idx_wide < 13'(MAX_BODIES));
    assign wbody = '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z,
                     mass: in_data.mass};
    assign raddr = i_reg[AW-1:0];

    gfd_body_mem #(
        .DEPTH(MAX_BODIES),
        .AW(AW)
    ) u_mem (
        .clk(clk),
        .we(mem_we),
        .waddr(idx_wide[AW-1:0]),
        .wdata(wbody),
        .raddr(raddr),
        .rdata(rbody)
    );

    gfd_engine u_eng (
        .clk(clk),
        .rst_n(rst_n),
        .req(eng_req),
        .busy(eng_busy),
        .done(eng_done),
        .result(eng_res)
    );

    assign dx = {rbody.x[31], rbody.x} - {px_reg[31], px_reg};
    assign dy = {rbody.y[31], rbody.y} - {py_reg[31], py_reg};
    assign dz = {rbody.z[31], rbody.z} - {pz_reg[31], pz_reg};
    assign amx = dx[32] ? (33'd0 - dx) : dx;
    assign amy = dy[32] ? (33'd0 - dy) : dy;
    assign amz = dz[32] ? (33'd0 - dz) : dz;
    assign s_sum = s_reg + eng_res[65:0];
    assign r_res = eng_res[34:0];
    assign skip = (r_res == '0) || (r_res < {19'd0, min_dist_reg});
    assign k_sat = (eng_res[95:64] != '0) ? 64'hFFFF_FFFF_FFFF_FFFF : eng_res[63:0];
    assign last = (i_reg == n_reg);
    assign out_free = !out_valid_reg || !out_stall;
    assign cnt_wide = 13'(body_count_reg);
    assign magx = mag64(ax_reg);
    assign magy = mag64(ay_reg);
    assign magz = mag64(az_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (in_data.cmd == CMD_QUERY))
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: state_next = last ? S_FX : S_DIFF;
            S_DIFF:  state_next = S_SQX;
            S_SQX:   state_next = eng_done ? S_SQY : S_SQX;
            S_SQY:   state_next = eng_done ? S_SQZ : S_SQY;
            S_SQZ:   state_next = eng_done ? S_SQRT : S_SQZ;
            S_SQRT:
            begin
                if (eng_done)
                begin
                    state_next = skip ? S_CHECK : S_R2;
                end
            end
            S_R2:    state_next = eng_done ? S_R3 : S_R2;
            S_R3:    state_next = eng_done ? S_DIV : S_R3;
            S_DIV:   state_next = eng_done ? S_CX : S_DIV;
            S_CX:    state_next = eng_done ? S_CY : S_CX;
            S_CY:    state_next = eng_done ? S_CZ : S_CY;
            S_CZ:    state_next = eng_done ? S_CHECK : S_CZ;
            S_FX:    state_next = eng_done ? S_FY : S_FX;
            S_FY:    state_next = eng_done ? S_FZ : S_FY;
            S_FZ:    state_next = eng_done ? S_OUT : S_FZ;
            S_OUT:   state_next = out_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != S_IDLE);
        eng_req.start = 1'b0;
        eng_req.op = OP_MUL;
        eng_req.a = '0;
        eng_req.b = '0;
        unique case (state_reg)
            S_CHECK:
            begin
                eng_req.start = last;
                eng_req.a = EW'(magx);
                eng_req.b = EW'(grav_reg);
            end
            S_DIFF:
            begin
                eng_req.start = 1'b1;
                eng_req.a = EW'(amx);
                eng_req.b = EW'(amx);
            end
            S_SQX:
            begin
                eng_req.start = eng_done;
                eng_req.a = EW'(my_reg);
                eng_req.b = EW'(my_reg);
            end
            S_SQY:
            begin
                eng_req.start = eng_done;
                eng_req.a = EW'(mz_reg);
                eng_req.b = EW'(mz_reg);
            end
            S_SQZ:
            begin
                eng_req.start = eng_done;
                eng_req.op = OP_SQRT;
                eng_req.a = EW'(s_sum);
            end
            S_SQRT:
            begin
                eng_req.start = eng_done && !skip;
                eng_req.a = EW'(r_res);
                eng_req.b = EW'(r_res);
            end
            S_R2:
            begin
                eng_req.start = eng_done;
                eng_req.a = eng_res;
                eng_req.b = EW'(r_reg);
            end
            S_R3:
            begin
                eng_req.start = eng_done;
                eng_req.op = OP_DIV;
                eng_req.a = {mass_reg, {(EW-32){1'b0}}};
                eng_req.b = eng_res;
            end
            S_DIV:
            begin
                eng_req.start = eng_done;
                eng_req.a = EW'(k_sat);
                eng_req.b = EW'(mx_reg);
            end
            S_CX:
            begin
                eng_req.start = eng_done;
                eng_req.a = EW'(k_reg);
                eng_req.b = EW'(my_reg);
            end
            S_CY:
            begin
                eng_req.start = eng_done;
                eng_req.a = EW'(k_reg);
                eng_req.b = EW'(mz_reg);
            end
            S_FX:
            begin
                eng_req.start = eng_done;
                eng_req.a = EW'(magy);
                eng_req.b = EW'(grav_reg);
            end
            S_FY:
            begin
                eng_req.start = eng_done;
                eng_req.a = EW'(magz);
                eng_req.b = EW'(grav_reg);
            end
            default:
            begin
                eng_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            body_count_reg <= BODY_COUNT_RST;
            grav_reg <= GRAV_CONST_RST;
            min_dist_reg <= MIN_DIST_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BODY_COUNT: body_count_reg <= cfg_data[6:0];
                    CFG_GRAV_CONST: grav_reg <= cfg_data;
                    CFG_MIN_DIST:   min_dist_reg <= cfg_data[15:0];
                    default:        body_count_reg <= body_count_reg;
                endcase
            end
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                px_reg <= in_data.pos_x;
                py_reg <= in_data.pos_y;
                pz_reg <= in_data.pos_z;
                n_reg <= (cnt_wide > 13'(MAX_BODIES)) ? CW'(MAX_BODIES) : CW'(body_count_reg);
                i_reg <= '0;
                ax_reg <= '0;
                ay_reg <= '0;
                az_reg <= '0;
            end
            S_DIFF:
            begin
                mx_reg <= amx;
                my_reg <= amy;
                mz_reg <= amz;
                sx_reg <= dx[32];
                sy_reg <= dy[32];
                sz_reg <= dz[32];
                mass_reg <= rbody.mass;
                i_reg <= i_reg + CW'(1);
            end
            S_SQX:
            begin
                s_reg <= eng_res[65:0];
            end
            S_SQY:
            begin
                if (eng_done)
                begin
                    s_reg <= s_sum;
                end
            end
            S_SQRT:
            begin
                r_reg <= r_res;
            end
            S_DIV:
            begin
                k_reg <= k_sat;
            end
            S_CX:
            begin
                if (eng_done)
                begin
                    ax_reg <= acc_add(ax_reg, sx_reg, eng_res);
                end
            end
            S_CY:
            begin
                if (eng_done)
                begin
                    ay_reg <= acc_add(ay_reg, sy_reg, eng_res);
                end
            end
            S_CZ:
            begin
                if (eng_done)
                begin
                    az_reg <= acc_add(az_reg, sz_reg, eng_res);
                end
            end
            S_FX:
            begin
                fx_reg <= fin32(ax_reg[63], eng_res);
            end
            S_FY:
            begin
                fy_reg <= fin32(ay_reg[63], eng_res);
            end
            S_FZ:
            begin
                fz_reg <= fin32(az_reg[63], eng_res);
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_reg.force_x <= fx_reg;
                    out_reg.force_y <= fy_reg;
                    out_reg.force_z <= fz_reg;
                end
            end
            default:
            begin
                s_reg <= s_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    `GFD_ASSERT_NEXT(a_query_holds, in_acc && (in_data.cmd == CMD_QUERY), in_stall)
    `GFD_ASSERT_SAME(a_start_free, eng_req.start, !eng_busy || eng_done)
    `GFD_ASSERT_SAME(a_index_range, state_reg != S_IDLE, i_reg <= n_reg)

endmodule

[sv/gfd_body_mem.sv]
module gfd_body_mem #(
    parameter int DEPTH = gfd_pkg::MAX_BODIES_DEF,
    parameter int AW = 6
) (
    input  logic           clk,
    input  logic           we,
    input  logic [AW-1:0]  waddr,
    input  gfd_pkg::body_t wdata,
    input  logic [AW-1:0]  raddr,
    output gfd_pkg::body_t rdata
);
    import gfd_pkg::*;

    body_t mem [DEPTH];
    body_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/gfd_engine.sv]
module gfd_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gfd_pkg::eng_req_t         req,
    output logic                      busy,
    output logic                      done,
    output logic [gfd_pkg::EW-1:0]    result
);
    import gfd_pkg::*;

    logic          busy_reg, busy_next;
    gfd_op_e       op_reg;
    logic [EW-1:0] x_reg, y_reg, z_reg;
    logic [6:0]    cnt_reg;
    logic [EW-1:0] sq_t;
    logic [EW-1:0] rem_sh;

    assign sq_t = y_reg + z_reg;
    assign rem_sh = {z_reg[EW-2:0], x_reg[EW-1]};

    always_comb
    begin
        unique case (op_reg)
            OP_MUL:  done = busy_reg && (y_reg == '0);
            OP_SQRT: done = busy_reg && (z_reg == '0);
            OP_DIV:  done = busy_reg && (cnt_reg == '0);
            default: done = busy_reg;
        endcase
        unique case (op_reg)
            OP_MUL:  result = z_reg;
            OP_SQRT: result = y_reg;
            default: result = x_reg;
        endcase
        busy_next = req.start ? 1'b1 : (done ? 1'b0 : busy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            op_reg <= OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            if (req.start)
            begin
                op_reg <= req.op;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg <= req.a;
            cnt_reg <= DIV_STEPS;
            unique case (req.op)
                OP_SQRT:
                begin
                    y_reg <= '0;
                    z_reg <= SQRT_BIT0;
                end
                default:
                begin
                    y_reg <= req.b;
                    z_reg <= '0;
                end
            endcase
        end
        else if (busy_reg && !done)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    if (y_reg[0])
                    begin
                        z_reg <= z_reg + x_reg;
                    end
                    x_reg <= {x_reg[EW-2:0], 1'b0};
                    y_reg <= {1'b0, y_reg[EW-1:1]};
                end
                OP_SQRT:
                begin
                    if (x_reg >= sq_t)
                    begin
                        x_reg <= x_reg - sq_t;
                        y_reg <= {1'b0, y_reg[EW-1:1]} + z_reg;
                    end
                    else
                    begin
                        y_reg <= {1'b0, y_reg[EW-1:1]};
                    end
                    z_reg <= {2'b00, z_reg[EW-1:2]};
                end
                default:
                begin
                    if (rem_sh >= y_reg)
                    begin
                        z_reg <= rem_sh - y_reg;
                        x_reg <= {x_reg[EW-2:0], 1'b1};
                    end
                    else
                    begin
                        z_reg <= rem_sh;
                        x_reg <= {x_reg[EW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 7'd1;
                end
            endcase
        end
    end

    assign busy = busy_reg;

endmodule
